FILE: sv/tsz_pkg.sv
package tsz_pkg;

	// Descriptor limits and GOB geometry
	localparam int MAX_LEVELS     = 16;
	localparam int GOB_X_LOG2     = 6;
	localparam int GOB_Y_LOG2     = 3;
	localparam int GOB_BYTES_LOG2 = 9;
	localparam logic [31:0] GOB_X = 32'd64;
	localparam logic [31:0] GOB_Y = 32'd8;
	localparam logic [31:0] GOB_Z = 32'd1;

	// Image kinds
	localparam logic [1:0] KIND_BUF = 2'd0;
	localparam logic [1:0] KIND_LIN = 2'd1;

	// Datapath operations, one per control word
	typedef logic [3:0] op_t;
	localparam op_t OP_NONE      = 4'd0;
	localparam op_t OP_DIVX_LOAD = 4'd1;
	localparam op_t OP_DIV_STEP  = 4'd2;
	localparam op_t OP_DIVY_LOAD = 4'd3;
	localparam op_t OP_FIT       = 4'd4;
	localparam op_t OP_SHR       = 4'd5;
	localparam op_t OP_MUL1      = 4'd6;
	localparam op_t OP_MUL2      = 4'd7;
	localparam op_t OP_ACC       = 4'd8;
	localparam op_t OP_BUF       = 4'd9;
	localparam op_t OP_DIVH_LOAD = 4'd10;
	localparam op_t OP_LINMUL    = 4'd11;
	localparam op_t OP_OUT       = 4'd12;

	// Jump conditions
	typedef logic [2:0] cond_t;
	localparam cond_t C_NEVER    = 3'd0;
	localparam cond_t C_ALWAYS   = 3'd1;
	localparam cond_t C_NO_IN    = 3'd2;
	localparam cond_t C_BUF      = 3'd3;
	localparam cond_t C_LIN      = 3'd4;
	localparam cond_t C_NO_LEV   = 3'd5;
	localparam cond_t C_MORE_LEV = 3'd6;
	localparam cond_t C_OUT_BUSY = 3'd7;

	// Program addresses
	typedef logic [4:0] step_t;
	localparam step_t ST_IDLE  = 5'd0;
	localparam step_t ST_DISP0 = 5'd1;
	localparam step_t ST_DISP1 = 5'd2;
	localparam step_t ST_DISP2 = 5'd3;
	localparam step_t ST_LVL   = 5'd4;
	localparam step_t ST_LDIV0 = 5'd5;
	localparam step_t ST_LDIV1 = 5'd6;
	localparam step_t ST_LDIVY = 5'd7;
	localparam step_t ST_LDIV2 = 5'd8;
	localparam step_t ST_LDIV3 = 5'd9;
	localparam step_t ST_FIT   = 5'd10;
	localparam step_t ST_SHR   = 5'd11;
	localparam step_t ST_MUL1  = 5'd12;
	localparam step_t ST_MUL2  = 5'd13;
	localparam step_t ST_ACC   = 5'd14;
	localparam step_t ST_WAIT  = 5'd15;
	localparam step_t ST_EMIT  = 5'd16;
	localparam step_t ST_BUF   = 5'd17;
	localparam step_t ST_LIN   = 5'd18;
	localparam step_t ST_LDIV4 = 5'd19;
	localparam step_t ST_LDIV5 = 5'd20;
	localparam step_t ST_LMUL  = 5'd21;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t tgt;
	} uword_t;

	// Sequencer to datapath
	typedef struct packed {
		logic load;
		op_t  op;
	} ctl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic kind_buf;
		logic kind_lin;
		logic no_lev;
		logic more_lev;
	} stat_t;

	// Divider control
	typedef struct packed {
		logic load;
		logic step;
	} div_ctl_t;

	// One image descriptor
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] width;
		logic [15:0] height;
		logic [15:0] depth;
		logic [2:0]  block_width_log2;
		logic [2:0]  block_height_log2;
		logic [2:0]  block_depth_log2;
		logic [4:0]  levels;
		logic [2:0]  bytes_per_block_log2;
		logic [3:0]  tile_width;
		logic [3:0]  tile_height;
		logic [19:0] pitch;
	} desc_t;

	// Control store: if cond holds jump to tgt, else advance by one
	function automatic uword_t ucode(input step_t a);
		uword_t w;
		w = '{op: OP_NONE, cond: C_ALWAYS, tgt: ST_IDLE};
		case (a)
			ST_IDLE:  w = '{op: OP_NONE,      cond: C_NO_IN,    tgt: ST_IDLE};
			ST_DISP0: w = '{op: OP_NONE,      cond: C_BUF,      tgt: ST_BUF};
			ST_DISP1: w = '{op: OP_NONE,      cond: C_LIN,      tgt: ST_LIN};
			ST_DISP2: w = '{op: OP_NONE,      cond: C_NO_LEV,   tgt: ST_WAIT};
			ST_LVL:   w = '{op: OP_DIVX_LOAD, cond: C_NEVER,    tgt: ST_IDLE};
			ST_LDIV0: w = '{op: OP_DIV_STEP,  cond: C_NEVER,    tgt: ST_IDLE};
			ST_LDIV1: w = '{op: OP_DIV_STEP,  cond: C_NEVER,    tgt: ST_IDLE};
			ST_LDIVY: w = '{op: OP_DIVY_LOAD, cond: C_NEVER,    tgt: ST_IDLE};
			ST_LDIV2: w = '{op: OP_DIV_STEP,  cond: C_NEVER,    tgt: ST_IDLE};
			ST_LDIV3: w = '{op: OP_DIV_STEP,  cond: C_NEVER,    tgt: ST_IDLE};
			ST_FIT:   w = '{op: OP_FIT,       cond: C_NEVER,    tgt: ST_IDLE};
			ST_SHR:   w = '{op: OP_SHR,       cond: C_NEVER,    tgt: ST_IDLE};
			ST_MUL1:  w = '{op: OP_MUL1,      cond: C_NEVER,    tgt: ST_IDLE};
			ST_MUL2:  w = '{op: OP_MUL2,      cond: C_NEVER,    tgt: ST_IDLE};
			ST_ACC:   w = '{op: OP_ACC,       cond: C_MORE_LEV, tgt: ST_LVL};
			ST_WAIT:  w = '{op: OP_NONE,      cond: C_OUT_BUSY, tgt: ST_WAIT};
			ST_EMIT:  w = '{op: OP_OUT,       cond: C_ALWAYS,   tgt: ST_IDLE};
			ST_BUF:   w = '{op: OP_BUF,       cond: C_ALWAYS,   tgt: ST_WAIT};
			ST_LIN:   w = '{op: OP_DIVH_LOAD, cond: C_NEVER,    tgt: ST_IDLE};
			ST_LDIV4: w = '{op: OP_DIV_STEP,  cond: C_NEVER,    tgt: ST_IDLE};
			ST_LDIV5: w = '{op: OP_DIV_STEP,  cond: C_NEVER,    tgt: ST_IDLE};
			ST_LMUL:  w = '{op: OP_LINMUL,    cond: C_ALWAYS,   tgt: ST_WAIT};
			default:  w = '{op: OP_NONE,      cond: C_ALWAYS,   tgt: ST_IDLE};
		endcase
		return w;
	endfunction

	// Mip extent, never below one
	function automatic logic [15:0] mip(input logic [15:0] v, input logic [3:0] lvl);
		logic [15:0] r;
		r = v >> lvl;
		return (r == 16'd0) ? 16'd1 : r;
	endfunction

	// Shift right rounding up
	function automatic logic [31:0] ceil_shr(input logic [31:0] v, input logic [4:0] s);
		logic [32:0] t;
		t = {1'b0, v} + ((33'd1 << s) - 33'd1);
		return t[31:0] >> s | (t[32] ? (32'd1 << (5'd31 - s)) << 1 : 32'd0);
	endfunction

	// Shrink a tile shift until unit << (s - 1) drops below dim
	function automatic logic [2:0] fit_shift(input logic [2:0] s, input logic [31:0] unit,
			input logic [31:0] dim);
		logic [2:0] cnt;
		cnt = 3'd0;
		for (int k = 0; k < 7; k++) begin
			if ((unit << k) < dim)
				cnt = cnt + 3'd1;
		end
		return (s < cnt) ? s : cnt;
	endfunction

endpackage

FILE: sv/block_linear_texture_size_unit.sv
// Texture size unit: takes one image descriptor per item on the s_axis side and returns its
// guest memory size in bytes, modulo 2^32, as one item on the m_axis side. Items are worked
// one at a time by a small control program over a shared 16-bit divider (eight quotient bits
// a cycle) and one shared 32x16 multiplier. A buffer image is sized by a single shift, a
// linear image by one division and one multiply, and a block-linear image by two divisions,
// a fit, shifts, two multiplies and an accumulate per mip level, at most sixteen. The next
// descriptor is taken while a finished size still waits on m_axis; the program holds before
// its output step only if that earlier size has not been taken yet.
module block_linear_texture_size_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// width[15:0], height[31:16], depth[47:32], block_width_log2[50:48],
	// block_height_log2[53:51], block_depth_log2[56:54], levels[61:57],
	// bytes_per_block_log2[64:62], tile_width[68:65], tile_height[72:69],
	// pitch[92:73], zero fill[95:93]
	input  logic [95:0]  s_axis_tdata,
	// kind[1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// size_bytes[31:0]
	output logic [31:0]  m_axis_tdata
);

	tsz_pkg::desc_t desc;
	tsz_pkg::ctl_t  ctl;
	tsz_pkg::stat_t stat;
	logic [31:0]    total;
	logic           out_valid_q;
	logic [31:0]    out_data_q;
	logic           out_busy;

	// Unpack the descriptor
	assign desc.kind                 = s_axis_tuser;
	assign desc.width                = s_axis_tdata[15:0];
	assign desc.height               = s_axis_tdata[31:16];
	assign desc.depth                = s_axis_tdata[47:32];
	assign desc.block_width_log2     = s_axis_tdata[50:48];
	assign desc.block_height_log2    = s_axis_tdata[53:51];
	assign desc.block_depth_log2     = s_axis_tdata[56:54];
	assign desc.levels               = s_axis_tdata[61:57];
	assign desc.bytes_per_block_log2 = s_axis_tdata[64:62];
	assign desc.tile_width           = s_axis_tdata[68:65];
	assign desc.tile_height          = s_axis_tdata[72:69];
	assign desc.pitch                = s_axis_tdata[92:73];

	assign out_busy = out_valid_q && !m_axis_tready;

	tsz_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.out_busy (out_busy),
		.stat     (stat),
		.ready    (s_axis_tready),
		.ctl      (ctl)
	);

	tsz_dpath u_dpath (
		.clk   (clk),
		.ctl   (ctl),
		.desc  (desc),
		.stat  (stat),
		.total (total)
	);

	// Output register: load on the emit step, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.op == tsz_pkg::OP_OUT)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.op == tsz_pkg::OP_OUT)
			out_data_q <= total;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

FILE: sv/tsz_div.sv
module tsz_div (
	input  logic                clk,
	input  tsz_pkg::div_ctl_t   ctl,
	input  logic [15:0]         num,
	input  logic [3:0]          den,
	output logic [15:0]         quo
);

	logic [15:0] n_q;
	logic [3:0]  r_q;
	logic [3:0]  d_q;
	logic        zero_q;
	logic [4:0]  rw;
	logic [7:0]  qb;

	// Eight restoring steps over the top dividend bits
	always_comb begin
		rw = {1'b0, r_q};
		qb = 8'd0;
		for (int i = 0; i < 8; i++) begin
			rw = {rw[3:0], n_q[15 - i]};
			if (rw >= {1'b0, d_q}) begin
				rw = rw - {1'b0, d_q};
				qb[7 - i] = 1'b1;
			end
		end
	end

	// Load a - 1 so that ceil(a / b) = floor((a - 1) / b) + 1
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			n_q    <= num - 16'd1;
			r_q    <= 4'd0;
			d_q    <= (den == 4'd0) ? 4'd1 : den;
			zero_q <= (num == 16'd0);
		end else if (ctl.step) begin
			n_q <= {n_q[7:0], qb};
			r_q <= rw[3:0];
		end
	end

	assign quo = zero_q ? 16'd0 : n_q + 16'd1;

endmodule

FILE: sv/tsz_seq.sv
module tsz_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             out_busy,
	input  tsz_pkg::stat_t   stat,
	output logic             ready,
	output tsz_pkg::ctl_t    ctl
);

	tsz_pkg::step_t  pc_q;
	tsz_pkg::uword_t uw;
	logic            taken;

	assign uw = tsz_pkg::ucode(pc_q);

	// Evaluate the jump condition of the current word
	always_comb begin
		case (uw.cond)
			tsz_pkg::C_NEVER:    taken = 1'b0;
			tsz_pkg::C_ALWAYS:   taken = 1'b1;
			tsz_pkg::C_NO_IN:    taken = !in_valid;
			tsz_pkg::C_BUF:      taken = stat.kind_buf;
			tsz_pkg::C_LIN:      taken = stat.kind_lin;
			tsz_pkg::C_NO_LEV:   taken = stat.no_lev;
			tsz_pkg::C_MORE_LEV: taken = stat.more_lev;
			tsz_pkg::C_OUT_BUSY: taken = out_busy;
			default:             taken = 1'b0;
		endcase
	end

	// Jump or advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pc_q <= tsz_pkg::ST_IDLE;
		else if (taken)
			pc_q <= uw.tgt;
		else
			pc_q <= pc_q + tsz_pkg::step_t'(1);
	end

	assign ready    = (pc_q == tsz_pkg::ST_IDLE);
	assign ctl.load = ready && in_valid;
	assign ctl.op   = uw.op;

endmodule

FILE: sv/tsz_dpath.sv
module tsz_dpath (
	input  logic             clk,
	input  tsz_pkg::ctl_t    ctl,
	input  tsz_pkg::desc_t   desc,
	output tsz_pkg::stat_t   stat,
	output logic [31:0]      total
);

	logic [1:0]  kind_q;
	logic [15:0] w_q, h_q, d_q;
	logic [2:0]  bw_q, bh_q, bd_q, bpp_q;
	logic [4:0]  nlev_q;
	logic [3:0]  tw_q, th_q;
	logic [19:0] pitch_q;
	logic [4:0]  lvl_q;
	logic [22:0] xb_q;
	logic [15:0] yb_q, zb_q;
	logic [2:0]  sx_q, sy_q, sz_q;
	logic [16:0] gxs_q;
	logic [13:0] gys_q;
	logic [15:0] gzs_q;
	logic [31:0] prod_q;
	logic [31:0] total_q;

	tsz_pkg::div_ctl_t div_ctl;
	logic [15:0] div_num;
	logic [3:0]  div_den;
	logic [15:0] div_q;
	logic [31:0] mul_a;
	logic [15:0] mul_b;
	logic [47:0] mul_full;
	logic [4:0]  acc_sh;

	// Feed the shared divider
	always_comb begin
		div_ctl.load = 1'b0;
		div_ctl.step = (ctl.op == tsz_pkg::OP_DIV_STEP);
		div_num      = tsz_pkg::mip(h_q, lvl_q[3:0]);
		div_den      = th_q;
		case (ctl.op)
			tsz_pkg::OP_DIVX_LOAD: begin
				div_ctl.load = 1'b1;
				div_num      = tsz_pkg::mip(w_q, lvl_q[3:0]);
				div_den      = tw_q;
			end
			tsz_pkg::OP_DIVY_LOAD: begin
				div_ctl.load = 1'b1;
			end
			tsz_pkg::OP_DIVH_LOAD: begin
				div_ctl.load = 1'b1;
				div_num      = h_q;
			end
			default: begin
				div_ctl.load = 1'b0;
			end
		endcase
	end

	tsz_div u_div (
		.clk (clk),
		.ctl (div_ctl),
		.num (div_num),
		.den (div_den),
		.quo (div_q)
	);

	// Shared multiplier operands
	always_comb begin
		case (ctl.op)
			tsz_pkg::OP_MUL1: begin
				mul_a = 32'(gxs_q);
				mul_b = 16'(gys_q);
			end
			tsz_pkg::OP_MUL2: begin
				mul_a = prod_q;
				mul_b = gzs_q;
			end
			default: begin
				mul_a = 32'(pitch_q);
				mul_b = div_q;
			end
		endcase
	end

	assign mul_full = mul_a * mul_b;
	assign acc_sh   = 5'(tsz_pkg::GOB_BYTES_LOG2) + 5'(sx_q) + 5'(sy_q) + 5'(sz_q);

	// Latch the descriptor and run the selected operation
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			kind_q  <= desc.kind;
			w_q     <= desc.width;
			h_q     <= desc.height;
			d_q     <= desc.depth;
			bw_q    <= desc.block_width_log2;
			bh_q    <= desc.block_height_log2;
			bd_q    <= desc.block_depth_log2;
			nlev_q  <= (desc.levels > 5'(tsz_pkg::MAX_LEVELS)) ?
				5'(tsz_pkg::MAX_LEVELS) : desc.levels;
			bpp_q   <= desc.bytes_per_block_log2;
			tw_q    <= desc.tile_width;
			th_q    <= desc.tile_height;
			pitch_q <= desc.pitch;
			lvl_q   <= 5'd0;
			total_q <= 32'd0;
		end else begin
			case (ctl.op)
				tsz_pkg::OP_DIVX_LOAD: zb_q <= tsz_pkg::mip(d_q, lvl_q[3:0]);
				tsz_pkg::OP_DIVY_LOAD: xb_q <= 23'(div_q) << bpp_q;
				tsz_pkg::OP_FIT: begin
					yb_q <= div_q;
					if (nlev_q == 5'd1) begin
						sx_q <= bw_q;
						sy_q <= bh_q;
						sz_q <= bd_q;
					end else begin
						sx_q <= tsz_pkg::fit_shift(bw_q, tsz_pkg::GOB_X, 32'(xb_q));
						sy_q <= tsz_pkg::fit_shift(bh_q, tsz_pkg::GOB_Y, 32'(div_q));
						sz_q <= tsz_pkg::fit_shift(bd_q, tsz_pkg::GOB_Z, 32'(zb_q));
					end
				end
				tsz_pkg::OP_SHR: begin
					gxs_q <= 17'(tsz_pkg::ceil_shr(32'(xb_q),
						5'(tsz_pkg::GOB_X_LOG2) + 5'(sx_q)));
					gys_q <= 14'(tsz_pkg::ceil_shr(32'(yb_q),
						5'(tsz_pkg::GOB_Y_LOG2) + 5'(sy_q)));
					gzs_q <= 16'(tsz_pkg::ceil_shr(32'(zb_q), 5'(sz_q)));
				end
				tsz_pkg::OP_MUL1:   prod_q  <= mul_full[31:0];
				tsz_pkg::OP_MUL2:   prod_q  <= mul_full[31:0];
				tsz_pkg::OP_ACC: begin
					total_q <= total_q + (prod_q << acc_sh);
					lvl_q   <= lvl_q + 5'd1;
				end
				tsz_pkg::OP_BUF:    total_q <= 32'(w_q) << bpp_q;
				tsz_pkg::OP_LINMUL: total_q <= mul_full[31:0];
				default: begin
					total_q <= total_q;
				end
			endcase
		end
	end

	assign stat.kind_buf = (kind_q == tsz_pkg::KIND_BUF);
	assign stat.kind_lin = (kind_q == tsz_pkg::KIND_LIN);
	assign stat.no_lev   = (nlev_q == 5'd0);
	assign stat.more_lev = ((lvl_q + 5'd1) < nlev_q);
	assign total         = total_q;

endmodule

FILE: sv/tsz_chk.sv
module tsz_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [31:0]  m_axis_tdata
);

	// Hold a stalled result item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result item changed while stalled");

	// One item in flight: ready drops after each accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item accepted while busy");

	// Ready returns only together with a fresh result
	a_ready_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_axis_tready) |-> m_axis_tvalid)
		else $error("ready returned without a result item");

	// A new result appears only at the end of an item's work
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result item without work");

endmodule

bind block_linear_texture_size_unit tsz_chk u_tsz_chk (.*);
